[rtl/core/congestion_window_and_rto_control_assert.svh]
// Assertion macros for the congestion window and RTO controller.
`ifndef CONGESTION_WINDOW_AND_RTO_CONTROL_ASSERT_SVH
`define CONGESTION_WINDOW_AND_RTO_CONTROL_ASSERT_SVH

`ifndef SYNTHESIS
`define CWRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CWRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CWRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CWRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/cwrc_pkg.sv]
// Types and constants shared by the congestion window and RTO controller.
package cwrc_pkg;

    localparam logic [1:0] MODE_ACK     = 2'd0;
    localparam logic [1:0] MODE_TIMEOUT = 2'd1;
    localparam logic [1:0] MODE_START   = 2'd2;

    localparam logic [1:0] PH_SLOW_START = 2'd0;
    localparam logic [1:0] PH_AVOIDANCE  = 2'd1;
    localparam logic [1:0] PH_RECOVERY   = 2'd2;
    localparam logic [1:0] PH_NONE       = 2'd3;

    localparam logic [1:0] CFG_ADV_WINDOW   = 2'd0;
    localparam logic [1:0] CFG_INIT_SEQ     = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_SEQ = 2'd2;

    localparam logic [15:0] ADV_WINDOW_RST = 16'd64;
    localparam logic [31:0] INIT_SEQ_RST   = 32'd4294962293;
    localparam logic [15:0] WIN_MAX        = 16'hFFFF;
    localparam logic [7:0]  DUP_LIMIT      = 8'd3;
    localparam logic [7:0]  DUP_MAX        = 8'hFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic        ack_flag;
        logic [31:0] peer_seq;
        logic [31:0] ack_number;
        logic [23:0] rtt_sample;
    } evt_item_t;

    typedef struct packed {
        logic [15:0] window;
        logic [15:0] slow_threshold;
        logic [31:0] retransmit_timeout;
        logic [1:0]  phase;
        logic [31:0] next_sequence;
    } res_item_t;

    typedef struct packed {
        logic [15:0] advertised_window;
        logic [31:0] initial_sequence;
        logic [31:0] expected_peer_seq;
    } cfg_regs_t;

    typedef struct packed {
        logic [15:0] window;
        logic [15:0] slow_threshold;
        logic [1:0]  phase;
        logic [31:0] next_sequence;
    } win_stat_t;

endpackage

[rtl/core/cwrc_rtt.sv]
// Smoothed RTT and deviation estimator with the retransmit timeout sum.
module cwrc_rtt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        upd,
    input  logic [23:0] sample,
    output logic [31:0] rto
);
    import cwrc_pkg::*;

    logic [31:0] srtt_reg, srtt_next;
    logic [31:0] dev_reg, dev_next;
    logic [31:0] srtt_base;
    logic [33:0] err;
    logic [33:0] mag;

    always_comb
    begin
        srtt_base = (srtt_reg == 32'd0) ? {8'd0, sample} : srtt_reg;
        err       = {10'd0, sample} - {5'd0, srtt_base[31:3]};
        mag       = err[33] ? (34'd0 - err) : err;
        srtt_next = srtt_reg;
        dev_next  = dev_reg;
        if (upd)
        begin
            srtt_next = srtt_base + err[31:0];
            dev_next  = dev_reg + mag[31:0] - {3'd0, dev_reg[31:3]};
        end
        rto = {3'd0, srtt_next[31:3]} + {1'd0, dev_next[31:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srtt_reg <= 32'd0;
            dev_reg  <= 32'd0;
        end
        else
        begin
            srtt_reg <= srtt_next;
            dev_reg  <= dev_next;
        end
    end

endmodule

[rtl/core/cwrc_window.sv]
// Congestion window, threshold, duplicate count, phase flags and send base.
`include "congestion_window_and_rto_control_assert.svh"

module cwrc_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                upd,
    input  cwrc_pkg::evt_item_t evt,
    input  cwrc_pkg::cfg_regs_t cfg,
    output cwrc_pkg::win_stat_t stat
);
    import cwrc_pkg::*;

    logic [15:0] cwnd_reg, cwnd_next;
    logic [15:0] ssth_reg, ssth_next;
    logic [7:0]  dup_reg, dup_next;
    logic        ss_reg, ss_next;
    logic        av_reg, av_next;
    logic        fr_reg, fr_next;
    logic [31:0] base_reg, base_next;

    logic        hit;
    logic [7:0]  dup_inc;
    logic [15:0] cwnd_inc;
    logic [15:0] half;
    logic [16:0] dbl;
    logic        grow_lin;

    always_comb
    begin
        hit      = evt.ack_flag && (evt.peer_seq == cfg.expected_peer_seq);
        dup_inc  = (dup_reg == DUP_MAX) ? dup_reg : dup_reg + 8'd1;
        cwnd_inc = (cwnd_reg == WIN_MAX) ? cwnd_reg : cwnd_reg + 16'd1;
        half     = {1'b0, cwnd_reg[15:1]};
        dbl      = {cwnd_reg, 1'b0};
        grow_lin = dbl > {1'b0, ssth_reg};

        cwnd_next = cwnd_reg;
        ssth_next = ssth_reg;
        dup_next  = dup_reg;
        ss_next   = ss_reg;
        av_next   = av_reg;
        fr_next   = fr_reg;
        base_next = base_reg;

        if (upd)
        begin
            case (evt.mode)
                MODE_ACK:
                begin
                    if (hit && (evt.ack_number == base_reg))
                    begin
                        dup_next = dup_inc;
                        if (dup_inc == DUP_LIMIT)
                        begin
                            ssth_next = half;
                            cwnd_next = half + 16'd3;
                        end
                        else if (dup_inc > DUP_LIMIT)
                        begin
                            cwnd_next = cwnd_inc;
                        end
                    end
                    else if (hit)
                    begin
                        if (grow_lin)
                        begin
                            if (!av_reg)
                            begin
                                fr_next = 1'b0;
                                ss_next = 1'b0;
                                av_next = 1'b1;
                            end
                            cwnd_next = cwnd_inc;
                        end
                        else
                        begin
                            cwnd_next = dbl[15:0];
                        end
                        if (dup_reg >= DUP_LIMIT)
                        begin
                            ss_next   = 1'b0;
                            av_next   = 1'b0;
                            fr_next   = 1'b1;
                            cwnd_next = ssth_reg;
                        end
                        dup_next  = 8'd0;
                        base_next = evt.ack_number;
                    end
                end
                MODE_TIMEOUT:
                begin
                    ss_next   = 1'b1;
                    ssth_next = half;
                    cwnd_next = 16'd1;
                    dup_next  = 8'd0;
                end
                MODE_START:
                begin
                    ss_next   = 1'b1;
                    av_next   = 1'b0;
                    fr_next   = 1'b0;
                    cwnd_next = 16'd1;
                    dup_next  = 8'd0;
                    ssth_next = cfg.advertised_window;
                    base_next = cfg.initial_sequence;
                end
                default:
                begin
                    cwnd_next = cwnd_reg;
                end
            endcase
        end

        stat.window         = cwnd_next;
        stat.slow_threshold = ssth_next;
        stat.next_sequence  = base_next;
        if (ss_next)
            stat.phase = PH_SLOW_START;
        else if (av_next)
            stat.phase = PH_AVOIDANCE;
        else if (fr_next)
            stat.phase = PH_RECOVERY;
        else
            stat.phase = PH_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cwnd_reg <= 16'd1;
            ssth_reg <= ADV_WINDOW_RST;
            dup_reg  <= 8'd0;
            ss_reg   <= 1'b1;
            av_reg   <= 1'b0;
            fr_reg   <= 1'b0;
            base_reg <= INIT_SEQ_RST;
        end
        else
        begin
            cwnd_reg <= cwnd_next;
            ssth_reg <= ssth_next;
            dup_reg  <= dup_next;
            ss_reg   <= ss_next;
            av_reg   <= av_next;
            fr_reg   <= fr_next;
            base_reg <= base_next;
        end
    end

    `CWRC_ASSERT_NXT(a_timeout_window, clk, rst_n, upd && (evt.mode == MODE_TIMEOUT), (cwnd_reg == 16'd1) && ss_reg && (dup_reg == 8'd0), "timeout did not drop window")
    `CWRC_ASSERT_NXT(a_start_base, clk, rst_n, upd && (evt.mode == MODE_START), (base_reg == $past(cfg.initial_sequence)) && !av_reg && !fr_reg, "start did not load send base")
    `CWRC_ASSERT_NXT(a_idle_hold, clk, rst_n, !upd, $stable(cwnd_reg) && $stable(ssth_reg) && $stable(base_reg), "window state moved without an item")

endmodule

[rtl/core/congestion_window_and_rto_control.sv]
// Congestion window and RTO controller top level: handshakes, config and result register.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle unless the result stalls; window per item, RTT per ACK.
// A stalled result holds; the input register still takes one more item behind it.
// Reset (rst_n, async, active low) loads config defaults, window 1, threshold 64,
// slow start, zero RTT estimates; payload registers are not reset.
`include "congestion_window_and_rto_control_assert.svh"

module congestion_window_and_rto_control (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                evt_valid,
    output logic                evt_stall,
    input  cwrc_pkg::evt_item_t evt,
    output logic                res_valid,
    input  logic                res_stall,
    output cwrc_pkg::res_item_t res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import cwrc_pkg::*;

    cfg_regs_t   cfg_reg;
    evt_item_t   evt_reg;
    logic        evt_valid_reg;
    res_item_t   res_reg, res_next;
    logic        res_valid_reg;
    logic        res_free;
    logic        advance;
    logic        evt_take;
    logic [31:0] rto;
    win_stat_t   stat;

    assign cfg_ready = 1'b1;
    assign res_free  = !res_valid_reg || !res_stall;
    assign advance   = evt_valid_reg && res_free;
    assign evt_stall = evt_valid_reg && !res_free;
    assign evt_take  = evt_valid && !evt_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.advertised_window <= ADV_WINDOW_RST;
            cfg_reg.initial_sequence  <= INIT_SEQ_RST;
            cfg_reg.expected_peer_seq <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ADV_WINDOW:   cfg_reg.advertised_window <= cfg_data[15:0];
                CFG_INIT_SEQ:     cfg_reg.initial_sequence  <= cfg_data;
                CFG_EXPECTED_SEQ: cfg_reg.expected_peer_seq <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    cwrc_rtt u_rtt (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (advance && (evt_reg.mode == MODE_ACK)),
        .sample (evt_reg.rtt_sample),
        .rto    (rto)
    );

    cwrc_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (advance),
        .evt   (evt_reg),
        .cfg   (cfg_reg),
        .stat  (stat)
    );

    always_comb
    begin
        res_next.window             = stat.window;
        res_next.slow_threshold     = stat.slow_threshold;
        res_next.retransmit_timeout = rto;
        res_next.phase              = stat.phase;
        res_next.next_sequence      = stat.next_sequence;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!evt_valid_reg || res_free)
                evt_valid_reg <= evt_take;
            if (res_free)
                res_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
            evt_reg <= evt;
        if (advance)
            res_reg <= res_next;
    end

    `CWRC_ASSERT_IMP(a_stall_cause, clk, rst_n, evt_stall, evt_valid_reg && res_valid_reg && res_stall, "input stalled with room downstream")
    `CWRC_ASSERT_NXT(a_item_moves, clk, rst_n, advance, res_valid_reg, "advanced item produced no result")
    `CWRC_ASSERT_NXT(a_no_extra, clk, rst_n, res_valid_reg && !res_stall && !evt_valid_reg, !res_valid_reg, "result repeated without an item")

endmodule

[sim/tb.sv]
// Testbench for the congestion window and RTO controller: predictor, scoreboard and stimulus.
`timescale 1ns / 100ps

module tb;
    import cwrc_pkg::*;

    class cwnd_scoreboard;
        logic [15:0] adv_window;
        logic [31:0] init_seq;
        logic [31:0] peer_seq_match;
        logic [31:0] srtt;
        logic [31:0] rtt_dev;
        int unsigned cwnd;
        int unsigned ssthresh;
        int unsigned dup_cnt;
        bit          in_ss;
        bit          in_ca;
        bit          in_fr;
        logic [31:0] send_base;
        res_item_t   window_q[$];
        int          errors;
        int          events;
        int          results;

        function new();
            adv_window     = ADV_WINDOW_RST;
            init_seq       = INIT_SEQ_RST;
            peer_seq_match = '0;
            srtt           = '0;
            rtt_dev        = '0;
            cwnd           = 1;
            ssthresh       = 32'(ADV_WINDOW_RST);
            dup_cnt        = 0;
            in_ss          = 1'b1;
            in_ca          = 1'b0;
            in_fr          = 1'b0;
            send_base      = INIT_SEQ_RST;
            errors         = 0;
            events         = 0;
            results        = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_ADV_WINDOW:   adv_window = data[15:0];
                CFG_INIT_SEQ:     init_seq = data;
                CFG_EXPECTED_SEQ: peer_seq_match = data;
                default: ;
            endcase
        endfunction

        function int unsigned sat_window(int unsigned v);
            return (v > WIN_MAX) ? WIN_MAX : v;
        endfunction

        function void update_rtt(logic [23:0] sample);
            longint s;
            longint q;
            longint err;
            longint mag;
            s = longint'(sample);
            if (srtt == 0)
            begin
                srtt = {8'd0, sample};
            end
            q = longint'(srtt >> 3);
            err = s - q;
            srtt = srtt + err[31:0];
            mag = (err < 0) ? -err : err;
            q = longint'(rtt_dev >> 3);
            mag = mag - q;
            rtt_dev = rtt_dev + mag[31:0];
        endfunction

        function void apply_ack(logic flag, logic [31:0] pseq, logic [31:0] ackn);
            if (!flag || pseq != peer_seq_match)
            begin
                return;
            end
            if (ackn == send_base)
            begin
                if (dup_cnt < DUP_MAX)
                begin
                    dup_cnt++;
                end
                if (dup_cnt == DUP_LIMIT)
                begin
                    ssthresh = cwnd >> 1;
                    cwnd = sat_window(ssthresh + DUP_LIMIT);
                end
                else if (dup_cnt > DUP_LIMIT)
                begin
                    cwnd = sat_window(cwnd + 1);
                end
                return;
            end
            if (cwnd * 2 > ssthresh)
            begin
                if (!in_ca)
                begin
                    in_fr = 1'b0;
                    in_ss = 1'b0;
                    in_ca = 1'b1;
                end
                cwnd = sat_window(cwnd + 1);
            end
            else
            begin
                cwnd = cwnd * 2;
            end
            if (dup_cnt >= DUP_LIMIT)
            begin
                in_ss = 1'b0;
                in_ca = 1'b0;
                in_fr = 1'b1;
                cwnd = ssthresh;
            end
            dup_cnt = 0;
            send_base = ackn;
        endfunction

        function void note_event(evt_item_t e);
            res_item_t r;
            events++;
            case (e.mode)
                MODE_ACK:
                begin
                    update_rtt(e.rtt_sample);
                    apply_ack(e.ack_flag, e.peer_seq, e.ack_number);
                end
                MODE_TIMEOUT:
                begin
                    in_ss = 1'b1;
                    ssthresh = cwnd >> 1;
                    cwnd = 1;
                    dup_cnt = 0;
                end
                MODE_START:
                begin
                    in_ss = 1'b1;
                    in_ca = 1'b0;
                    in_fr = 1'b0;
                    cwnd = 1;
                    dup_cnt = 0;
                    ssthresh = 32'(adv_window);
                    send_base = init_seq;
                end
                default: ;
            endcase
            r.window = 16'(cwnd);
            r.slow_threshold = 16'(ssthresh);
            r.retransmit_timeout = (srtt >> 3) + (rtt_dev >> 1);
            r.phase = in_ss ? PH_SLOW_START : in_ca ? PH_AVOIDANCE : in_fr ? PH_RECOVERY : PH_NONE;
            r.next_sequence = send_base;
            window_q.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(res_item_t r);
            res_item_t e;
            results++;
            if (window_q.size() == 0)
            begin
                $error("result with nothing pending: window %0d next_sequence %0d",
                       r.window, r.next_sequence);
                errors++;
                return;
            end
            e = window_q.pop_front();
            check_field("window", 32'(e.window), 32'(r.window));
            check_field("slow_threshold", 32'(e.slow_threshold), 32'(r.slow_threshold));
            check_field("retransmit_timeout", e.retransmit_timeout, r.retransmit_timeout);
            check_field("phase", 32'(e.phase), 32'(r.phase));
            check_field("next_sequence", e.next_sequence, r.next_sequence);
        endfunction

        function int expected_pending();
            return window_q.size();
        endfunction
    endclass

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        evt_valid = 1'b0;
    logic        evt_stall;
    evt_item_t   evt = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_item_t   res;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ADV_WINDOW;
    logic [31:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    cwnd_scoreboard sb = new();

    congestion_window_and_rto_control u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (evt_valid && !evt_stall)
            begin
                sb.note_event(evt);
            end
            if (res_valid && !res_stall)
            begin
                sb.check_result(res);
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_index, cfg_data);
            end
            if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic evt_item_t mk_item(logic [1:0] mode, logic flag, logic [31:0] pseq,
                                          logic [31:0] ackn, logic [23:0] rtt);
        evt_item_t it;
        it.mode = mode;
        it.ack_flag = flag;
        it.peer_seq = pseq;
        it.ack_number = ackn;
        it.rtt_sample = rtt;
        return it;
    endfunction

    function automatic logic [23:0] rnd_rtt();
        int p;
        p = $urandom_range(9);
        if (p == 0)
        begin
            return '0;
        end
        if (p < 3)
        begin
            return 24'($urandom);
        end
        return 24'($urandom_range(20, 100000));
    endfunction

    function automatic evt_item_t good_ack(logic [31:0] ackn);
        return mk_item(MODE_ACK, 1'b1, sb.peer_seq_match, ackn, rnd_rtt());
    endfunction

    task automatic send_event(input evt_item_t item);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_valid <= 1'b1;
        evt <= item;
        @(negedge clk);
        while (evt_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic drain();
        evt_valid <= 1'b0;
        while (sb.expected_pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        while (!cfg_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic write_config(input logic [15:0] adv, input logic [31:0] iseq,
                                input logic [31:0] pseq);
        write_reg(CFG_ADV_WINDOW, {16'd0, adv});
        write_reg(CFG_INIT_SEQ, iseq);
        write_reg(CFG_EXPECTED_SEQ, pseq);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        send_event(mk_item(MODE_UNUSED, 1'b1, $urandom, $urandom, 24'($urandom)));
        send_event(mk_item(MODE_TIMEOUT, 1'b0, '0, '0, '0));
        send_event(mk_item(MODE_START, 1'b1, '1, '1, '1));
        send_event(mk_item(MODE_ACK, 1'b0, '0, '0, '0));
        send_event(mk_item(MODE_ACK, 1'b1, 32'hFFFF_FFFF, '0, 24'hFF_FFFF));
        send_event(mk_item(MODE_ACK, 1'b1, '0, sb.send_base + 1, 24'd1000));
        send_event(mk_item(MODE_ACK, 1'b1, '0, 32'hFFFF_FFFF, '0));
        send_event(mk_item(MODE_ACK, 1'b1, '0, '0, 24'hFF_FFFF));
        repeat (4) send_event(mk_item(MODE_ACK, 1'b1, '0, sb.send_base, 24'd500));
        send_event(mk_item(MODE_ACK, 1'b1, '0, sb.send_base + 7, 24'd600));
        send_event(mk_item(MODE_ACK, 1'b1, '0, sb.send_base + 9, 24'd700));
        send_event(mk_item(MODE_TIMEOUT, 1'b1, '1, '1, '1));
        send_event(mk_item(MODE_UNUSED, 1'b1, '1, '1, '1));
        repeat (3) send_event(mk_item(MODE_ACK, 1'b1, '0, sb.send_base, 24'd800));
        send_event(mk_item(MODE_ACK, 1'b1, '0, sb.send_base + 3, 24'd900));
        send_event(mk_item(MODE_START, 1'b0, '0, '0, '0));
    endtask

    task automatic run_traffic(input int target);
        int sent;
        int pick;
        int burst;
        evt_item_t it;
        sent = 0;
        send_event(mk_item(MODE_START, 1'b1, $urandom, $urandom, rnd_rtt()));
        while (sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
            begin
                drain();
            end
            else if (pick < 42)
            begin
                send_event(good_ack(sb.send_base + $urandom_range(1, 4000)));
                sent++;
            end
            else if (pick < 60)
            begin
                burst = (pick == 59) ? 258 : $urandom_range(1, 6);
                repeat (burst) send_event(good_ack(sb.send_base));
                send_event(good_ack(sb.send_base + $urandom_range(1, 4000)));
                sent += burst + 1;
            end
            else if (pick < 66)
            begin
                send_event(mk_item(MODE_TIMEOUT, 1'($urandom), $urandom, $urandom, rnd_rtt()));
                sent++;
            end
            else if (pick < 69)
            begin
                send_event(mk_item(MODE_START, 1'($urandom), $urandom, $urandom, rnd_rtt()));
                sent++;
            end
            else if (pick < 80)
            begin
                it = good_ack($urandom);
                if ($urandom_range(1) == 1)
                begin
                    it.ack_flag = 1'b0;
                end
                else
                begin
                    it.peer_seq = it.peer_seq ^ ($urandom | 32'd1);
                end
                send_event(it);
                sent++;
            end
            else if (pick < 88)
            begin
                it = mk_item(2'($urandom_range(3)), 1'($urandom), $urandom, $urandom,
                             24'($urandom));
                send_event(it);
                if (it.mode != MODE_UNUSED)
                begin
                    sent++;
                end
            end
            else
            begin
                burst = $urandom_range(5, 20);
                repeat (burst) send_event(good_ack(sb.send_base + $urandom_range(1, 4000)));
                sent += burst;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain();

        write_config(16'd1, 32'd0, 32'hFFFF_FFFF);
        send_idle_pct = 16;
        recv_stall_pct = 65;
        run_traffic(430);
        drain();

        write_config(16'hFFFF, 32'hFFFF_FFFF, 32'd0);
        send_idle_pct = 65;
        recv_stall_pct = 16;
        run_traffic(430);
        drain();

        write_config(16'($urandom_range(2, 65534)), $urandom, $urandom);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_traffic(440);
        drain();
        repeat (8) @(posedge clk);

        $display("Checked %0d results for %0d events: slow start, avoidance, fast recovery,",
                 sb.results, sb.events);
        $display("dup-ACK bursts, timeouts, restarts and noise under three config/load profiles.");
        if (sb.errors == 0 && sb.expected_pending() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/cwrc_pkg.sv
rtl/core/cwrc_rtt.sv
rtl/core/cwrc_window.sv
rtl/core/congestion_window_and_rto_control.sv
sim/tb.sv
